// ===== design/lowbit_weight_dot_product_core_defines.svh =====
// Assertion macros used by the checker file of the low-bit dot product core.
`ifndef LOWBIT_WEIGHT_DOT_PRODUCT_CORE_DEFINES_SVH
`define LOWBIT_WEIGHT_DOT_PRODUCT_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define LWDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lowbit dot product check failed");

// Check a condition in the cycle after its trigger.
`define LWDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lowbit dot product check failed");

`endif

// ===== design/lwdp_pkg.sv =====
// Types and constants of the low-bit weight dot product core.
package lwdp_pkg;

    localparam int X_W      = 16;
    localparam int WBITS_W  = 16;
    localparam int CNT_W    = 3;
    localparam int SCALE_W  = 16;
    localparam int WGT_W    = 5;
    localparam int PROD_W   = X_W + WGT_W;
    localparam int ITEM_W   = PROD_W + 2;
    localparam int GROUP_W  = 40;
    localparam int SCALED_W = GROUP_W + SCALE_W;
    localparam int ROW_W    = 64;
    localparam int SUM_W    = ROW_W + 1;
    localparam int OUT_W    = 48;
    localparam int MAX_HW_LANES = 4;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [PADDR_W-3:0] REG_WEIGHT_FORMAT = '0;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
    localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FMT_2BIT = 2'd0,
        FMT_4BIT = 2'd1,
        FMT_3BIT = 2'd2
    } t_wfmt;

    localparam logic [1:0] FMT_RESET = FMT_4BIT;

    typedef struct packed {
        logic close;     // group ends on this item
        logic row_last;  // row ends on this item
    } t_ctl;

endpackage

// ===== design/lwdp_lane.sv =====
// One lane: decode the lane's weight code and register activation times weight.
module lwdp_lane #(
    parameter int LANE = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_adv,
    input  logic                                   i_active,
    input  logic [1:0]                             i_fmt,
    input  logic signed [lwdp_pkg::X_W-1:0]        i_x,
    input  logic [lwdp_pkg::WBITS_W-1:0]           i_wbits,
    output logic signed [lwdp_pkg::PROD_W-1:0]     o_prod
);

    logic signed [lwdp_pkg::WGT_W-1:0]  w_weight;
    logic signed [lwdp_pkg::PROD_W-1:0] w_xe;
    logic signed [lwdp_pkg::PROD_W-1:0] w_we;
    logic signed [lwdp_pkg::PROD_W-1:0] r_prod;

    always_comb begin
        case (i_fmt)
            lwdp_pkg::FMT_2BIT: begin
                w_weight = lwdp_pkg::WGT_W'({3'b000, i_wbits[2*LANE +: 2]}) - 5'sd2;
            end
            lwdp_pkg::FMT_4BIT: begin
                w_weight = lwdp_pkg::WGT_W'({1'b0, i_wbits[4*LANE +: 4]}) - 5'sd8;
            end
            lwdp_pkg::FMT_3BIT: begin
                w_weight = lwdp_pkg::WGT_W'({2'b00, i_wbits[8+LANE], i_wbits[2*LANE +: 2]})
                           - 5'sd4;
            end
            default: begin
                w_weight = '0;
            end
        endcase
    end

    assign w_xe = lwdp_pkg::PROD_W'(i_x);
    assign w_we = lwdp_pkg::PROD_W'(w_weight);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= i_active ? w_xe * w_we : '0;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== design/lwdp_merge.sv =====
// Merge the lane products: group sum, group scaling, saturating row sum, result register.
module lwdp_merge #(
    parameter int NL = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_valid,
    input  lwdp_pkg::t_ctl                         i_ctl,
    input  logic signed [lwdp_pkg::SCALE_W-1:0]    i_scale,
    input  logic [NL-1:0][lwdp_pkg::PROD_W-1:0]    i_prod,
    output logic                                   o_valid,
    output logic signed [lwdp_pkg::OUT_W-1:0]      o_result,
    output logic                                   o_sat
);

    logic signed [lwdp_pkg::ITEM_W-1:0]   w_item;
    logic signed [lwdp_pkg::GROUP_W-1:0]  w_total;
    logic signed [lwdp_pkg::GROUP_W-1:0]  r_group;

    logic                                 r_b_valid;
    lwdp_pkg::t_ctl                       r_b_ctl;
    logic signed [lwdp_pkg::GROUP_W-1:0]  r_b_gsum;
    logic signed [lwdp_pkg::SCALE_W-1:0]  r_b_scale;

    logic                                 r_c_valid;
    lwdp_pkg::t_ctl                       r_c_ctl;
    logic signed [lwdp_pkg::SCALED_W-1:0] r_c_scaled;

    logic signed [lwdp_pkg::ROW_W-1:0]    r_row;
    logic signed [lwdp_pkg::SUM_W-1:0]    w_sum;
    logic signed [lwdp_pkg::ROW_W-1:0]    w_row_add;
    logic signed [lwdp_pkg::ROW_W-1:0]    w_row_new;
    logic                                 w_fits;

    logic                                 r_out_valid;
    logic signed [lwdp_pkg::OUT_W-1:0]    r_out_result;
    logic                                 r_out_sat;

    // Item sum over the lanes, then wrap into the group sum.
    always_comb begin
        w_item = '0;
        for (int k = 0; k < NL; k++) begin
            w_item = w_item + lwdp_pkg::ITEM_W'($signed(i_prod[k]));
        end
        w_total = r_group + lwdp_pkg::GROUP_W'(w_item);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group   <= '0;
            r_b_valid <= 1'b0;
            r_b_ctl   <= '0;
        end else if (i_adv) begin
            r_b_valid <= i_valid;
            r_b_ctl   <= i_ctl;
            if (i_valid) begin
                r_group <= i_ctl.close ? '0 : w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_gsum  <= w_total;
            r_b_scale <= i_scale;
        end
    end

    // Scale the closed group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_c_ctl   <= '0;
        end else if (i_adv) begin
            r_c_valid <= r_b_valid;
            r_c_ctl   <= r_b_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_scaled <= lwdp_pkg::SCALED_W'(r_b_gsum) * lwdp_pkg::SCALED_W'(r_b_scale);
        end
    end

    // Saturating row accumulate and clip to the output width.
    always_comb begin
        w_sum = lwdp_pkg::SUM_W'(r_row) + lwdp_pkg::SUM_W'(r_c_scaled);
        if (w_sum[lwdp_pkg::SUM_W-1] != w_sum[lwdp_pkg::ROW_W-1]) begin
            w_row_add = w_sum[lwdp_pkg::SUM_W-1] ? lwdp_pkg::ROW_MIN : lwdp_pkg::ROW_MAX;
        end else begin
            w_row_add = w_sum[lwdp_pkg::ROW_W-1:0];
        end
        w_row_new = r_c_ctl.close ? w_row_add : r_row;
        w_fits    = (w_row_new[lwdp_pkg::ROW_W-1:lwdp_pkg::OUT_W-1] == '0) ||
                    (w_row_new[lwdp_pkg::ROW_W-1:lwdp_pkg::OUT_W-1] == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= r_c_valid && r_c_ctl.row_last;
            if (r_c_valid) begin
                r_row <= r_c_ctl.row_last ? '0 : w_row_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_c_valid && r_c_ctl.row_last) begin
            r_out_sat <= !w_fits;
            if (w_fits) begin
                r_out_result <= w_row_new[lwdp_pkg::OUT_W-1:0];
            end else begin
                r_out_result <= w_row_new[lwdp_pkg::ROW_W-1] ? lwdp_pkg::OUT_MIN
                                                             : lwdp_pkg::OUT_MAX;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;
    assign o_sat    = r_out_sat;

endmodule

// ===== design/lowbit_weight_dot_product_core.sv =====
// Top level of the low-bit weight dot product core: config register, lanes and merge pipeline.
//
// Streams one dot product of Q7.8 activations with packed 2-, 3- or 4-bit weights.
// Each item carries four activations, their packed weight codes, a valid lane count, a
// Q2.13 group scale and end-of-group / end-of-row flags. Up to four lanes (min of LANES
// and 4) each register activation times decoded weight in the first stage; the merge
// stage adds the lane products into a 40-bit wrapping group sum, a 40x16 multiplier
// scales each closed group, and a saturating 64-bit row sum is clipped to 48 bits (21
// fraction bits) and presented on the output register when the row closes. The block
// takes one item per cycle while o_in_stall is low, each passing the lane, group, scaling
// and output registers. The whole pipeline holds while a result sits in the output register
// with the output stalled, so o_in_stall follows i_out_stall only while o_out_valid is high.
// weight_format (APB byte address 0, reset 1: four-bit) selects 0 two-bit offset 2,
// 1 four-bit offset 8, 2 three-bit offset 4 (high bits in weight_bits[11:8]); code 3
// gives zero weights. Write it only while no item is in flight.
module lowbit_weight_dot_product_core #(
    parameter int LANES = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [lwdp_pkg::X_W-1:0]        i_x_lane0,
    input  logic signed [lwdp_pkg::X_W-1:0]        i_x_lane1,
    input  logic signed [lwdp_pkg::X_W-1:0]        i_x_lane2,
    input  logic signed [lwdp_pkg::X_W-1:0]        i_x_lane3,
    input  logic [lwdp_pkg::WBITS_W-1:0]           i_weight_bits,
    input  logic [lwdp_pkg::CNT_W-1:0]             i_lane_count,
    input  logic signed [lwdp_pkg::SCALE_W-1:0]    i_group_scale,
    input  logic                                   i_group_last,
    input  logic                                   i_row_last,
    // Result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [lwdp_pkg::OUT_W-1:0]      o_row_result,
    output logic                                   o_saturated,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lwdp_pkg::PADDR_W-1:0]           paddr,
    input  logic [lwdp_pkg::PDATA_W-1:0]           pwdata,
    output logic [lwdp_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    localparam int NL = (LANES < lwdp_pkg::MAX_HW_LANES) ? LANES : lwdp_pkg::MAX_HW_LANES;

    logic [1:0]                                 r_weight_format;
    logic                                       w_adv;
    logic                                       r_a_valid;
    lwdp_pkg::t_ctl                             r_a_ctl;
    logic signed [lwdp_pkg::SCALE_W-1:0]        r_a_scale;
    logic [lwdp_pkg::MAX_HW_LANES-1:0][lwdp_pkg::X_W-1:0] w_x;
    logic [NL-1:0][lwdp_pkg::PROD_W-1:0]        w_prod;

    // Config register: written on the APB access phase at byte addresses 0 to 3, other addresses are ignored.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_format <= lwdp_pkg::FMT_RESET;
        end else if (psel && penable && pwrite &&
                     paddr[lwdp_pkg::PADDR_W-1:2] == lwdp_pkg::REG_WEIGHT_FORMAT) begin
            r_weight_format <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[lwdp_pkg::PADDR_W-1:2] == lwdp_pkg::REG_WEIGHT_FORMAT)
                    ? lwdp_pkg::PDATA_W'(r_weight_format) : '0;

    // Advance every stage unless a result waits on a stalled output.
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    assign w_x = {i_x_lane3, i_x_lane2, i_x_lane1, i_x_lane0};

    // First stage control: item flags and scale travel beside the lane products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_ctl   <= '0;
        end else if (w_adv) begin
            r_a_valid       <= i_in_valid;
            r_a_ctl.close    <= i_group_last || i_row_last;
            r_a_ctl.row_last <= i_row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_scale <= i_group_scale;
        end
    end

    // Lanes: a lane contributes only below the valid lane count.
    for (genvar gi = 0; gi < NL; gi++) begin : g_lane
        lwdp_lane #(
            .LANE (gi)
        ) u_lane (
            .i_clk    (i_clk),
            .i_adv    (w_adv),
            .i_active (i_lane_count > lwdp_pkg::CNT_W'(gi)),
            .i_fmt    (r_weight_format),
            .i_x      (w_x[gi]),
            .i_wbits  (i_weight_bits),
            .o_prod   (w_prod[gi])
        );
    end

    lwdp_merge #(
        .NL (NL)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (r_a_valid),
        .i_ctl    (r_a_ctl),
        .i_scale  (r_a_scale),
        .i_prod   (w_prod),
        .o_valid  (o_out_valid),
        .o_result (o_row_result),
        .o_sat    (o_saturated)
    );

endmodule

// ===== design/lwdp_checker.sv =====
// Port-level checks of the low-bit dot product core, bound to the top level.
`include "lowbit_weight_dot_product_core_defines.svh"

module lwdp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [lwdp_pkg::OUT_W-1:0]   o_row_result,
    input logic                                o_saturated
);

    // Hold a stalled result.
    `LWDP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_row_result) && $stable(o_saturated))

    // A clipped result sits exactly at one of the range limits.
    `LWDP_ASSERT_NOW(a_sat_limit, i_clk, i_rst_n, o_out_valid && o_saturated, o_row_result == lwdp_pkg::OUT_MAX || o_row_result == lwdp_pkg::OUT_MIN)

    // Input stalls only while a result is blocked downstream.
    `LWDP_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule

bind lowbit_weight_dot_product_core lwdp_checker u_lwdp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_row_result (o_row_result),
    .o_saturated  (o_saturated)
);
